FILE: hdl/dti_pkg.sv
// Shared types, constants and character-class functions for the dictionary token indexer.
`default_nettype none
package dti_pkg;

  localparam int TOKEN_LIMIT = 40;
  localparam int LEN_W       = $clog2(TOKEN_LIMIT);
  localparam int ADDR_W      = LEN_W;
  localparam int IDX_W       = LEN_W + 1;
  localparam int CAP_W       = 24;
  localparam int POS_W       = 32;

  localparam logic [LEN_W-1:0] STORE_LIMIT = LEN_W'(TOKEN_LIMIT - 1);
  localparam logic [CAP_W-1:0] CAP_RESET   = {CAP_W{1'b1}};

  localparam logic [7:0] TAG_BYTE        = 8'h40;
  localparam logic [7:0] THREE_BYTE_LEAD = 8'h8F;
  localparam logic [7:0] KANJI_LOW       = 8'hB0;
  localparam logic [7:0] ASCII_LIMIT     = 8'd127;
  localparam logic [7:0] EUC_LOW         = 8'h80;
  localparam logic [7:0] DIGIT_NINE      = 8'h39;
  localparam logic [7:0] HYPHEN          = 8'h2D;
  localparam logic [7:0] PERIOD          = 8'h2E;

  typedef enum logic [1:0] {
    KIND_ENTRY = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_OVF   = 2'd2
  } res_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEEP,
    ST_TAG,
    ST_EUC,
    ST_LOOP_INIT,
    ST_LOOP,
    ST_READ,
    ST_EMIT,
    ST_END,
    ST_COUNT,
    ST_DONE
  } state_e;

  // Request from the sequencer to the result queue.
  typedef struct packed {
    logic             push;
    logic             flush;
    res_kind_e        kind;
    logic [POS_W-1:0] value;
  } res_req_t;

  typedef struct packed {
    logic push_ready;
    logic flush_ready;
  } res_stat_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h30 && c <= DIGIT_NINE);
  endfunction

  function automatic logic is_start(input logic [7:0] c);
    return is_alnum(c) || (c >= EUC_LOW) || (c == TAG_BYTE);
  endfunction

  function automatic logic is_cont(input logic [7:0] c);
    return is_alnum(c) || (c >= EUC_LOW) || (c == HYPHEN) || (c == PERIOD);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/dti_alu.sv
// Shared adder and magnitude compare used by the sequencer for offsets and capacity checks.
`default_nettype none
module dti_alu (
  input  wire logic [dti_pkg::POS_W-1:0] a_i,
  input  wire logic [dti_pkg::POS_W-1:0] b_i,
  output logic      [dti_pkg::POS_W-1:0] sum_o,
  output logic                           ge_o
);

  assign sum_o = a_i + b_i;
  assign ge_o  = (a_i >= b_i);

endmodule
`default_nettype wire

FILE: hdl/dti_tokbuf.sv
// Token byte store: one write port, one registered read port.
`default_nettype none
module dti_tokbuf (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [dti_pkg::ADDR_W-1:0] waddr_i,
  input  wire logic [7:0]                 wdata_i,
  input  wire logic [dti_pkg::ADDR_W-1:0] raddr_i,
  output logic      [7:0]                 rdata_o
);

  logic [7:0] mem_q [dti_pkg::TOKEN_LIMIT];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: hdl/dti_outq.sv
// Result queue: one held-back stage so the last result of a transaction can be marked.
`default_nettype none
module dti_outq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dti_pkg::res_req_t             req_i,
  output dti_pkg::res_stat_t                 stat_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [1:0]                    result_kind_o,
  output logic      [dti_pkg::POS_W-1:0]     result_value_o,
  output logic                               last_of_run_o
);

  logic                       pend_v_q, pend_v_d;
  dti_pkg::res_kind_e         pend_kind_q, pend_kind_d;
  logic [dti_pkg::POS_W-1:0]  pend_val_q, pend_val_d;
  logic                       out_v_q, out_v_d;
  dti_pkg::res_kind_e         out_kind_q, out_kind_d;
  logic [dti_pkg::POS_W-1:0]  out_val_q, out_val_d;
  logic                       out_last_q, out_last_d;
  logic                       out_free;

  assign out_free           = !out_v_q || !out_stall_i;
  assign stat_o.push_ready  = !pend_v_q || out_free;
  assign stat_o.flush_ready = !pend_v_q || out_free;

  always_comb begin
    pend_v_d    = pend_v_q;
    pend_kind_d = pend_kind_q;
    pend_val_d  = pend_val_q;
    out_v_d     = out_v_q && out_stall_i;
    out_kind_d  = out_kind_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    if (req_i.push && stat_o.push_ready) begin
      // Move the held result out, keep the new one back.
      if (pend_v_q) begin
        out_v_d    = 1'b1;
        out_kind_d = pend_kind_q;
        out_val_d  = pend_val_q;
        out_last_d = 1'b0;
      end
      pend_v_d    = 1'b1;
      pend_kind_d = req_i.kind;
      pend_val_d  = req_i.value;
    end else if (req_i.flush && stat_o.flush_ready && pend_v_q) begin
      out_v_d    = 1'b1;
      out_kind_d = pend_kind_q;
      out_val_d  = pend_val_q;
      out_last_d = 1'b1;
      pend_v_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_kind_q <= pend_kind_d;
    pend_val_q  <= pend_val_d;
    out_kind_q  <= out_kind_d;
    out_val_q   <= out_val_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o    = out_v_q;
  assign result_kind_o  = out_kind_q;
  assign result_value_o = out_val_q;
  assign last_of_run_o  = out_last_q;

endmodule
`default_nettype wire

FILE: hdl/dti_ctrl.sv
// Sequencer: token tracking, judging and entry emission through the shared ALU.
`default_nettype none
module dti_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    text_byte_i,
  input  wire logic                          end_of_text_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [dti_pkg::CAP_W-1:0]     cfg_wdata_i,
  output logic                               mem_we_o,
  output logic      [dti_pkg::ADDR_W-1:0]    mem_waddr_o,
  output logic      [7:0]                    mem_wdata_o,
  output logic      [dti_pkg::ADDR_W-1:0]    mem_raddr_o,
  input  wire logic [7:0]                    mem_rdata_i,
  output logic      [dti_pkg::POS_W-1:0]     alu_a_o,
  output logic      [dti_pkg::POS_W-1:0]     alu_b_o,
  input  wire logic [dti_pkg::POS_W-1:0]     alu_sum_i,
  input  wire logic                          alu_ge_i,
  output dti_pkg::res_req_t                  req_o,
  input  wire dti_pkg::res_stat_t            stat_i
);

  dti_pkg::state_e            state_q, state_d, ret_q, ret_d;
  logic                       in_token_q, in_token_d;
  logic [dti_pkg::LEN_W-1:0]  len_q, len_d;
  logic [dti_pkg::POS_W-1:0]  start_q, start_d;
  logic [dti_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [dti_pkg::POS_W-1:0]  base_q, base_d;
  logic [dti_pkg::POS_W-1:0]  offset_q, offset_d;
  logic [dti_pkg::POS_W-1:0]  entries_q, entries_d;
  logic                       ovf_q, ovf_d;
  logic [dti_pkg::CAP_W-1:0]  cap_q;
  logic [7:0]                 b0_q, b0_d, b1_q, b1_d;
  logic                       off_q, off_d;
  logic [dti_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic                       last_q, last_d;

  logic                       accept;
  logic                       keep;
  logic [dti_pkg::LEN_W-1:0]  slen;
  logic [7:0]                 lead;
  logic [7:0]                 c;

  assign in_stall_o = (state_q != dti_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign keep = !((len_q <= dti_pkg::LEN_W'(2)) && (b0_q < dti_pkg::ASCII_LIMIT)) ||
                ((len_q == dti_pkg::LEN_W'(2)) && (b1_q <= dti_pkg::DIGIT_NINE));
  assign slen = len_q - dti_pkg::LEN_W'(off_q);
  assign lead = off_q ? b1_q : b0_q;
  assign c    = mem_rdata_i;

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    in_token_d = in_token_q;
    len_d      = len_q;
    start_d    = start_q;
    pos_d      = pos_q;
    base_d     = base_q;
    offset_d   = offset_q;
    entries_d  = entries_q;
    ovf_d      = ovf_q;
    b0_d       = b0_q;
    b1_d       = b1_q;
    off_d      = off_q;
    idx_d      = idx_q;
    last_d     = last_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = text_byte_i;
    mem_raddr_o = dti_pkg::ADDR_W'(idx_q + dti_pkg::IDX_W'(off_q));
    alu_a_o     = base_q;
    alu_b_o     = dti_pkg::POS_W'(idx_q);
    req_o.push  = 1'b0;
    req_o.flush = 1'b0;
    req_o.kind  = dti_pkg::KIND_ENTRY;
    req_o.value = offset_q;

    case (state_q)
      dti_pkg::ST_IDLE: begin
        if (accept) begin
          last_d = end_of_text_i;
          pos_d  = pos_q + dti_pkg::POS_W'(1);
          if (!in_token_q) begin
            if (dti_pkg::is_start(text_byte_i)) begin
              in_token_d  = 1'b1;
              start_d     = pos_q;
              b0_d        = text_byte_i;
              len_d       = dti_pkg::LEN_W'(1);
              mem_we_o    = 1'b1;
              mem_waddr_o = '0;
            end
          end else if (dti_pkg::is_cont(text_byte_i)) begin
            if (len_q < dti_pkg::STORE_LIMIT) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = dti_pkg::ADDR_W'(len_q);
              len_d       = len_q + dti_pkg::LEN_W'(1);
              if (len_q == dti_pkg::LEN_W'(1)) begin
                b1_d = text_byte_i;
              end
            end
          end else begin
            in_token_d = 1'b0;
            state_d    = dti_pkg::ST_KEEP;
          end
          if (state_d != dti_pkg::ST_KEEP && end_of_text_i) begin
            state_d = dti_pkg::ST_COUNT;
          end
        end
      end

      dti_pkg::ST_KEEP: begin
        off_d = 1'b0;
        if (!keep) begin
          state_d = dti_pkg::ST_END;
        end else if (b0_q < dti_pkg::ASCII_LIMIT) begin
          offset_d = start_q;
          ret_d    = dti_pkg::ST_TAG;
          state_d  = dti_pkg::ST_EMIT;
        end else if (b0_q == dti_pkg::ASCII_LIMIT) begin
          state_d = dti_pkg::ST_END;
        end else begin
          base_d   = start_q;
          offset_d = start_q;
          ret_d    = dti_pkg::ST_LOOP_INIT;
          state_d  = dti_pkg::ST_EMIT;
        end
      end

      dti_pkg::ST_TAG: begin
        alu_a_o = start_q;
        alu_b_o = dti_pkg::POS_W'(1);
        if (b0_q == dti_pkg::TAG_BYTE) begin
          offset_d = alu_sum_i;
          base_d   = alu_sum_i;
          off_d    = 1'b1;
          ret_d    = dti_pkg::ST_EUC;
          state_d  = dti_pkg::ST_EMIT;
        end else begin
          state_d = dti_pkg::ST_END;
        end
      end

      dti_pkg::ST_EUC: begin
        if (len_q <= dti_pkg::LEN_W'(1) || b1_q <= dti_pkg::ASCII_LIMIT) begin
          state_d = dti_pkg::ST_END;
        end else begin
          state_d = dti_pkg::ST_LOOP_INIT;
        end
      end

      dti_pkg::ST_LOOP_INIT: begin
        idx_d   = (lead == dti_pkg::THREE_BYTE_LEAD) ? dti_pkg::IDX_W'(3)
                                                     : dti_pkg::IDX_W'(2);
        state_d = dti_pkg::ST_LOOP;
      end

      dti_pkg::ST_LOOP: begin
        // Read address is issued here; data lands in the next state.
        if (idx_q < dti_pkg::IDX_W'(slen)) begin
          state_d = dti_pkg::ST_READ;
        end else begin
          state_d = dti_pkg::ST_END;
        end
      end

      dti_pkg::ST_READ: begin
        idx_d = idx_q + ((c == dti_pkg::THREE_BYTE_LEAD) ? dti_pkg::IDX_W'(3)
                                                         : dti_pkg::IDX_W'(2));
        if (c >= dti_pkg::KANJI_LOW || c == dti_pkg::THREE_BYTE_LEAD) begin
          offset_d = alu_sum_i;
          ret_d    = dti_pkg::ST_LOOP;
          state_d  = dti_pkg::ST_EMIT;
        end else begin
          state_d = dti_pkg::ST_LOOP;
        end
      end

      dti_pkg::ST_EMIT: begin
        alu_a_o = entries_q;
        alu_b_o = dti_pkg::POS_W'(cap_q);
        if (ovf_q) begin
          state_d = ret_q;
        end else if (stat_i.push_ready) begin
          req_o.push = 1'b1;
          if (alu_ge_i) begin
            req_o.kind  = dti_pkg::KIND_OVF;
            req_o.value = '0;
            ovf_d       = 1'b1;
          end else begin
            entries_d = entries_q + dti_pkg::POS_W'(1);
          end
          state_d = ret_q;
        end
      end

      dti_pkg::ST_END: begin
        len_d   = '0;
        state_d = last_q ? dti_pkg::ST_COUNT : dti_pkg::ST_DONE;
      end

      dti_pkg::ST_COUNT: begin
        if (stat_i.push_ready) begin
          req_o.push  = 1'b1;
          req_o.kind  = dti_pkg::KIND_COUNT;
          req_o.value = entries_q;
          in_token_d  = 1'b0;
          len_d       = '0;
          pos_d       = '0;
          entries_d   = '0;
          ovf_d       = 1'b0;
          state_d     = dti_pkg::ST_DONE;
        end
      end

      dti_pkg::ST_DONE: begin
        // Release the held result with its last mark.
        req_o.flush = 1'b1;
        if (stat_i.flush_ready) begin
          state_d = dti_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = dti_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dti_pkg::ST_IDLE;
      ret_q      <= dti_pkg::ST_IDLE;
      in_token_q <= 1'b0;
      len_q      <= '0;
      start_q    <= '0;
      pos_q      <= '0;
      entries_q  <= '0;
      ovf_q      <= 1'b0;
      cap_q      <= dti_pkg::CAP_RESET;
      last_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_q      <= ret_d;
      in_token_q <= in_token_d;
      len_q      <= len_d;
      start_q    <= start_d;
      pos_q      <= pos_d;
      entries_q  <= entries_d;
      ovf_q      <= ovf_d;
      last_q     <= last_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    offset_q <= offset_d;
    b0_q     <= b0_d;
    b1_q     <= b1_d;
    off_q    <= off_d;
    idx_q    <= idx_d;
  end

endmodule
`default_nettype wire

FILE: hdl/dictionary_token_indexer.sv
// Top level of the dictionary token indexer.
//
//   Channel  | Handshake                    | Payload
//   ---------+------------------------------+-------------------------------------------
//   input    | in_valid_i / in_stall_o      | text_byte_i, end_of_text_i
//   result   | out_valid_o / out_stall_i    | result_kind_o, result_value_o, last_of_run_o
//   config   | cfg_we_i                     | cfg_wdata_i (index capacity)
//
// A plain byte is taken without stalling the input. A token end passes through accept, judge,
// close and release, plus an emit step per entry the token would emit, a tag check for an ASCII
// token, an EUC check if tagged, and a loop set-up, a loop and read step per scanned position
// and a loop exit for a kanji walk through the store and adder. The end of text adds the count.
// Reset clears all control state; the token store needs no clearing. Output stalls hold the
// sequencer wherever it waits to push a result.
`default_nettype none
module dictionary_token_indexer (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [7:0]                 text_byte_i,
  input  wire logic                       end_of_text_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic      [1:0]                 result_kind_o,
  output logic      [dti_pkg::POS_W-1:0]  result_value_o,
  output logic                            last_of_run_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [dti_pkg::CAP_W-1:0]  cfg_wdata_i
);

  logic                       mem_we;
  logic [dti_pkg::ADDR_W-1:0] mem_waddr;
  logic [7:0]                 mem_wdata;
  logic [dti_pkg::ADDR_W-1:0] mem_raddr;
  logic [7:0]                 mem_rdata;
  logic [dti_pkg::POS_W-1:0]  alu_a, alu_b, alu_sum;
  logic                       alu_ge;
  dti_pkg::res_req_t          req;
  dti_pkg::res_stat_t         stat;

  dti_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .alu_a_o       (alu_a),
    .alu_b_o       (alu_b),
    .alu_sum_i     (alu_sum),
    .alu_ge_i      (alu_ge),
    .req_o         (req),
    .stat_i        (stat)
  );

  dti_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sum_o (alu_sum),
    .ge_o  (alu_ge)
  );

  dti_tokbuf u_tokbuf (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  dti_outq u_outq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .result_value_o (result_value_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule
`default_nettype wire
